@@ src/noise_channel_lfsr_envelope_core_assert.svh @@
// Assertion macros shared by the checker files of the noise channel core.
// No dependencies; include by bare file name.
`ifndef NOISE_CHANNEL_LFSR_ENVELOPE_CORE_ASSERT_SVH
`define NOISE_CHANNEL_LFSR_ENVELOPE_CORE_ASSERT_SVH

// Same-cycle implication, held off while reset is asserted.
`define NCLE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define NCLE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/ncle_pkg.sv @@
// Shared types, operation codes and helpers for the noise channel core.
// No dependencies; used by ncle_channel and the top level.
package ncle_pkg;

    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 16;

    // Operation codes carried on the input tuser
    localparam logic [2:0] FUNC_WRITE    = 3'd0;
    localparam logic [2:0] FUNC_READ     = 3'd1;
    localparam logic [2:0] FUNC_ADVANCE  = 3'd2;
    localparam logic [2:0] FUNC_LENGTH   = 3'd3;
    localparam logic [2:0] FUNC_ENVELOPE = 3'd4;

    // Control register indexes
    localparam logic [1:0] REG_LENGTH   = 2'd0;
    localparam logic [1:0] REG_ENVELOPE = 2'd1;
    localparam logic [1:0] REG_POLY     = 2'd2;
    localparam logic [1:0] REG_CONTROL  = 2'd3;

    localparam logic [7:0] LENGTH_REG_RESET = 8'hFF;
    localparam logic [6:0] LENGTH_LIMIT     = 7'd64;
    localparam logic [3:0] VOLUME_MAX       = 4'd15;
    localparam logic [3:0] SAMPLE_DAC_OFF   = 4'd7;
    localparam logic [3:0] SAMPLE_CHAN_OFF  = 4'd15;

    typedef struct packed {
        logic [2:0] func;
        logic [1:0] reg_index;
        logic [7:0] write_data;
        logic [7:0] cycle_count;
    } item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [3:0] sample;
        logic       channel_on;
        logic       dac_on;
    } result_t;

    // Reload value of the shift timer: (16 * divider) << shift, divider 0 counts as 0.5
    function automatic logic [22:0] shift_period(input logic [7:0] poly);
        logic [6:0] base;
        base = (poly[2:0] == 3'd0) ? 7'd8 : {poly[2:0], 4'b0000};
        return {16'b0, base} << poly[7:4];
    endfunction

endpackage

@@ src/noise_channel_lfsr_envelope_core.sv @@
// Top level of the noise channel core: stream handshake, input and result registers.
// Depends on ncle_pkg and ncle_channel.
//
//  Channel   | Direction | tdata fields (LSB first)                     | tuser
//  ----------+-----------+----------------------------------------------+-------
//  s_axis    | in        | reg_index[1:0] write_data[9:2] cyc[17:10]    | func
//  m_axis    | out       | read_data[7:0] sample[11:8] chan[12] dac[13] | -
//
//  One beat in, one beat out. A beat waits in the input register until the result
//  register is free or being drained; it is then applied to the channel state and
//  its result is loaded into the result register at the same edge, to show on m_axis.
//  Throughput is one beat per clock while m_axis does not stall, set by the single
//  state update per cycle. A stalled m_axis holds the result; the input register
//  then fills and s_axis_tready drops until the result is taken.
//  rst_n clears all valid flags and the channel state at once; no clearing pass.
module noise_channel_lfsr_envelope_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // reg_index[1:0], write_data[9:2], cycle_count[17:10], zero fill above
    input  logic [ncle_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // func[2:0]
    input  logic [ncle_pkg::S_TUSER_W-1:0] s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // read_data[7:0], sample[11:8], channel_on[12], dac_on[13], zero fill above
    output logic [ncle_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    logic              in_valid_reg, in_valid_next;
    ncle_pkg::item_t   in_item_reg;
    ncle_pkg::item_t   in_item;
    logic              out_valid_reg, out_valid_next;
    ncle_pkg::result_t out_result_reg;
    ncle_pkg::result_t step_result;
    logic              s_beat;
    logic              advance;

    // Move the held beat on whenever the result register is free or being drained
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_beat        = s_axis_tvalid && s_axis_tready;

    // Unpack the incoming beat
    always_comb
    begin
        in_item.func        = s_axis_tuser;
        in_item.reg_index   = s_axis_tdata[1:0];
        in_item.write_data  = s_axis_tdata[9:2];
        in_item.cycle_count = s_axis_tdata[17:10];
    end

    assign in_valid_next  = s_beat || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_axis_tready);

    ncle_channel u_channel (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (in_item_reg),
        .result (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: input loads on an accepted beat, result on advance; hold otherwise
    always_ff @(posedge clk)
    begin
        if (s_beat)
        begin
            in_item_reg <= in_item;
        end
        if (advance)
        begin
            out_result_reg <= step_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_result_reg.dac_on, out_result_reg.channel_on,
                            out_result_reg.sample, out_result_reg.read_data};

endmodule

@@ src/ncle_channel.sv @@
// Channel state of the noise core: control registers, LFSR, envelope, length.
// Depends on ncle_pkg. Applies one item per step and reports the new state.
module ncle_channel (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  ncle_pkg::item_t   item,
    output ncle_pkg::result_t result
);

    logic [7:0]  length_reg, length_next;
    logic [7:0]  envelope_reg, envelope_next;
    logic [7:0]  poly_reg, poly_next;
    logic [7:0]  control_reg, control_next;
    logic        chan_en_reg, chan_en_next;
    logic        dac_en_reg, dac_en_next;
    logic [14:0] shift_reg, shift_next;
    logic        short_mode_reg, short_mode_next;
    logic [22:0] shift_timer_reg, shift_timer_next;
    logic [3:0]  volume_reg, volume_next;
    logic [2:0]  env_period_reg, env_period_next;
    logic        env_inc_reg, env_inc_next;
    logic [2:0]  env_timer_reg, env_timer_next;
    logic [6:0]  length_count_reg, length_count_next;

    logic [7:0]  rd_data;
    logic        fb_bit;
    logic [15:0] shift_wide;

    // Feedback tap and one LFSR step; the feedback bit enters at bit 15, and at bit 7 in short mode
    always_comb
    begin
        fb_bit = ~(shift_reg[0] ^ shift_reg[1]);
        shift_wide = {fb_bit, shift_reg};
        if (short_mode_reg)
        begin
            shift_wide[7] = fb_bit;
        end
    end

    always_comb
    begin
        length_next       = length_reg;
        envelope_next     = envelope_reg;
        poly_next         = poly_reg;
        control_next      = control_reg;
        chan_en_next      = chan_en_reg;
        dac_en_next       = dac_en_reg;
        shift_next        = shift_reg;
        short_mode_next   = short_mode_reg;
        shift_timer_next  = shift_timer_reg;
        volume_next       = volume_reg;
        env_period_next   = env_period_reg;
        env_inc_next      = env_inc_reg;
        env_timer_next    = env_timer_reg;
        length_count_next = length_count_reg;
        rd_data           = 8'h00;

        unique case (item.func)
            ncle_pkg::FUNC_WRITE:
            begin
                unique case (item.reg_index)
                    ncle_pkg::REG_LENGTH:   length_next   = item.write_data;
                    ncle_pkg::REG_ENVELOPE: envelope_next = item.write_data;
                    ncle_pkg::REG_POLY:     poly_next     = item.write_data;
                    ncle_pkg::REG_CONTROL:
                    begin
                        control_next = item.write_data;
                        if (item.write_data[7])
                        begin
                            // trigger: DAC power comes from the upper five envelope bits
                            if (envelope_reg[7:3] == 5'd0)
                            begin
                                dac_en_next  = 1'b0;
                                chan_en_next = 1'b0;
                            end
                            else
                            begin
                                dac_en_next       = 1'b1;
                                volume_next       = envelope_reg[7:4];
                                env_period_next   = envelope_reg[2:0];
                                env_inc_next      = envelope_reg[3];
                                env_timer_next    = envelope_reg[2:0];
                                length_count_next = {1'b0, length_reg[5:0]};
                                short_mode_next   = poly_reg[3];
                                shift_timer_next  = ncle_pkg::shift_period(poly_reg);
                                shift_next        = 15'd0;
                                chan_en_next      = 1'b1;
                            end
                        end
                    end
                endcase
            end
            ncle_pkg::FUNC_READ:
            begin
                unique case (item.reg_index)
                    ncle_pkg::REG_LENGTH:   rd_data = length_reg;
                    ncle_pkg::REG_ENVELOPE: rd_data = envelope_reg;
                    ncle_pkg::REG_POLY:     rd_data = poly_reg;
                    ncle_pkg::REG_CONTROL:  rd_data = control_reg;
                endcase
            end
            ncle_pkg::FUNC_ADVANCE:
            begin
                // on expiry reload without carrying the excess, then step the LFSR once; else count down
                if ({15'd0, item.cycle_count} >= shift_timer_reg)
                begin
                    shift_timer_next = ncle_pkg::shift_period(poly_reg);
                    shift_next       = shift_wide[15:1];
                end
                else
                begin
                    shift_timer_next = shift_timer_reg - {15'd0, item.cycle_count};
                end
            end
            ncle_pkg::FUNC_LENGTH:
            begin
                if (control_reg[6] && (length_count_reg < ncle_pkg::LENGTH_LIMIT))
                begin
                    length_count_next = length_count_reg + 7'd1;
                    if (length_count_next == ncle_pkg::LENGTH_LIMIT)
                    begin
                        chan_en_next = 1'b0;
                    end
                end
            end
            ncle_pkg::FUNC_ENVELOPE:
            begin
                if (env_period_reg != 3'd0)
                begin
                    if (env_timer_reg <= 3'd1)
                    begin
                        env_timer_next = env_period_reg;
                        if (env_inc_reg)
                        begin
                            if (volume_reg != ncle_pkg::VOLUME_MAX)
                            begin
                                volume_next = volume_reg + 4'd1;
                            end
                        end
                        else if (volume_reg != 4'd0)
                        begin
                            volume_next = volume_reg - 4'd1;
                        end
                    end
                    else
                    begin
                        env_timer_next = env_timer_reg - 3'd1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        result.read_data  = rd_data;
        result.channel_on = chan_en_next;
        result.dac_on     = dac_en_next;
        if (!dac_en_next)
        begin
            result.sample = ncle_pkg::SAMPLE_DAC_OFF;
        end
        else if (!chan_en_next)
        begin
            result.sample = ncle_pkg::SAMPLE_CHAN_OFF;
        end
        else
        begin
            result.sample = shift_next[0] ? volume_next : 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg       <= ncle_pkg::LENGTH_REG_RESET;
            envelope_reg     <= 8'h00;
            poly_reg         <= 8'h00;
            control_reg      <= 8'h00;
            chan_en_reg      <= 1'b0;
            dac_en_reg       <= 1'b0;
            shift_reg        <= 15'd0;
            short_mode_reg   <= 1'b0;
            shift_timer_reg  <= 23'd0;
            volume_reg       <= 4'd0;
            env_period_reg   <= 3'd0;
            env_inc_reg      <= 1'b0;
            env_timer_reg    <= 3'd0;
            length_count_reg <= 7'd0;
        end
        else if (step)
        begin
            length_reg       <= length_next;
            envelope_reg     <= envelope_next;
            poly_reg         <= poly_next;
            control_reg      <= control_next;
            chan_en_reg      <= chan_en_next;
            dac_en_reg       <= dac_en_next;
            shift_reg        <= shift_next;
            short_mode_reg   <= short_mode_next;
            shift_timer_reg  <= shift_timer_next;
            volume_reg       <= volume_next;
            env_period_reg   <= env_period_next;
            env_inc_reg      <= env_inc_next;
            env_timer_reg    <= env_timer_next;
            length_count_reg <= length_count_next;
        end
    end

endmodule

@@ src/ncle_checker.sv @@
// Port-level checker for the noise channel core, bound to the top level.
// Depends on ncle_pkg and noise_channel_lfsr_envelope_core_assert.svh.
`include "noise_channel_lfsr_envelope_core_assert.svh"

module ncle_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic [ncle_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input logic [ncle_pkg::S_TUSER_W-1:0] s_axis_tuser,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [ncle_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    logic unused_in;

    assign unused_in = s_axis_tvalid ^ (^s_axis_tdata) ^ (^s_axis_tuser);

    // Stalled result holds
    `NCLE_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && (unused_in == unused_in), "result changed under stall")

    // Empty result register never blocks the input
    `NCLE_ASSERT_NOW(a_ready_when_empty, clk, rst_n, !m_axis_tvalid, s_axis_tready, "input blocked with empty output")

    // DAC off gives the mid-level sample
    `NCLE_ASSERT_NOW(a_dac_off_sample, clk, rst_n, m_axis_tvalid && !m_axis_tdata[13], m_axis_tdata[11:8] == ncle_pkg::SAMPLE_DAC_OFF, "wrong sample with DAC off")

    // Channel on only with DAC on; disabled channel gives full-scale sample
    `NCLE_ASSERT_NOW(a_chan_off_sample, clk, rst_n, m_axis_tvalid && m_axis_tdata[13] && !m_axis_tdata[12], m_axis_tdata[11:8] == ncle_pkg::SAMPLE_CHAN_OFF, "wrong sample with channel off")

endmodule

bind noise_channel_lfsr_envelope_core ncle_checker u_ncle_checker (.*);

@@ dv/noise_channel_checker.sv @@
`timescale 1ns / 1ps
// Result checker for noise_channel_lfsr_envelope_core: tracks the channel state from
// accepted s_axis beats, queues the expected m_axis beats and compares them field by field.
// Depends on ncle_pkg for operation codes, register indexes and limits.
module noise_channel_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    input  logic [ncle_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input  logic [ncle_pkg::S_TUSER_W-1:0] s_axis_tuser,
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [ncle_pkg::M_TDATA_W-1:0] m_axis_tdata,
    output int                             mismatch_count,
    output int                             results_pending
);
    import ncle_pkg::*;

    localparam int PRINT_LIMIT = 100;

    // Shadow of the channel state
    logic [7:0]  nr_length;
    logic [7:0]  nr_envelope;
    logic [7:0]  nr_poly;
    logic [7:0]  nr_control;
    logic        chan_en;
    logic        dac_en;
    logic        short_lfsr;
    logic        env_up;
    logic [15:0] lfsr;
    logic [22:0] lfsr_timer;
    logic [3:0]  vol;
    logic [2:0]  env_per;
    logic [2:0]  env_cnt;
    logic [6:0]  len_cnt;

    result_t expected_beats[$];
    int      result_no;

    // Timer reload in CPU cycles: 16 per divider step, a zero divider gives 8
    function automatic logic [22:0] lfsr_reload(input logic [7:0] poly);
        logic [29:0] ticks;
        if (poly[2:0] == 3'd0)
            ticks = 30'd8;
        else
            ticks = 30'(poly[2:0]) * 30'd16;
        ticks = ticks << poly[7:4];
        return ticks[22:0];
    endfunction

    task automatic trigger_channel();
        // DAC needs a nonzero start volume or an increasing envelope
        if (nr_envelope[7:3] == 5'd0) begin
            dac_en  = 1'b0;
            chan_en = 1'b0;
        end
        else begin
            dac_en     = 1'b1;
            vol        = nr_envelope[7:4];
            env_per    = nr_envelope[2:0];
            env_up     = nr_envelope[3];
            env_cnt    = nr_envelope[2:0];
            len_cnt    = {1'b0, nr_length[5:0]};
            short_lfsr = nr_poly[3];
            lfsr_timer = lfsr_reload(nr_poly);
            lfsr       = 16'd0;
            chan_en    = 1'b1;
        end
    endtask

    task automatic apply_beat(input logic [2:0] func, input logic [1:0] idx,
                              input logic [7:0] data, input logic [7:0] cyc,
                              output result_t res);
        logic        fb;
        logic [15:0] next_lfsr;
        res = '0;
        case (func)
            FUNC_WRITE: begin
                case (idx)
                    REG_LENGTH:   nr_length = data;
                    REG_ENVELOPE: nr_envelope = data;
                    REG_POLY:     nr_poly = data;
                    default: begin
                        nr_control = data;
                        if (data[7])
                            trigger_channel();
                    end
                endcase
            end
            FUNC_READ: begin
                case (idx)
                    REG_LENGTH:   res.read_data = nr_length;
                    REG_ENVELOPE: res.read_data = nr_envelope;
                    REG_POLY:     res.read_data = nr_poly;
                    default:      res.read_data = nr_control;
                endcase
            end
            FUNC_ADVANCE: begin
                // Expiry reloads without carrying the excess and steps once
                if ({15'd0, cyc} >= lfsr_timer) begin
                    lfsr_timer = lfsr_reload(nr_poly);
                    fb = ~(lfsr[0] ^ lfsr[1]);
                    next_lfsr = lfsr | {fb, 15'd0};
                    if (short_lfsr)
                        next_lfsr[7] = fb;
                    lfsr = next_lfsr >> 1;
                end
                else begin
                    lfsr_timer = lfsr_timer - 23'(cyc);
                end
            end
            FUNC_LENGTH: begin
                if (nr_control[6] && len_cnt < LENGTH_LIMIT) begin
                    len_cnt = len_cnt + 7'd1;
                    if (len_cnt == LENGTH_LIMIT)
                        chan_en = 1'b0;
                end
            end
            FUNC_ENVELOPE: begin
                if (env_per != 3'd0) begin
                    if (env_cnt <= 3'd1) begin
                        env_cnt = env_per;
                        if (env_up) begin
                            if (vol != VOLUME_MAX)
                                vol = vol + 4'd1;
                        end
                        else if (vol != 4'd0) begin
                            vol = vol - 4'd1;
                        end
                    end
                    else begin
                        env_cnt = env_cnt - 3'd1;
                    end
                end
            end
            default: ;
        endcase
        if (!dac_en)
            res.sample = SAMPLE_DAC_OFF;
        else if (!chan_en)
            res.sample = SAMPLE_CHAN_OFF;
        else
            res.sample = lfsr[0] ? vol : 4'd0;
        res.channel_on = chan_en;
        res.dac_on     = dac_en;
    endtask

    task automatic report_mismatch(input string field, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("%0t: result beat %0d: %s is %0d, expected %0d",
                     $time, result_no, field, got, want);
    endtask

    always @(posedge clk or negedge rst_n) begin
        result_t want;
        result_t fresh;
        if (!rst_n) begin
            nr_length       = LENGTH_REG_RESET;
            nr_envelope     = 8'd0;
            nr_poly         = 8'd0;
            nr_control      = 8'd0;
            chan_en         = 1'b0;
            dac_en          = 1'b0;
            short_lfsr      = 1'b0;
            env_up          = 1'b0;
            lfsr            = 16'd0;
            lfsr_timer      = 23'd0;
            vol             = 4'd0;
            env_per         = 3'd0;
            env_cnt         = 3'd0;
            len_cnt         = 7'd0;
            result_no       = 0;
            mismatch_count  = 0;
            results_pending = 0;
            expected_beats.delete();
        end
        else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_beats.size() == 0) begin
                    report_mismatch("beat with nothing expected, tdata", m_axis_tdata, 0);
                end
                else begin
                    want = expected_beats.pop_front();
                    if (m_axis_tdata[7:0] != want.read_data)
                        report_mismatch("read_data", m_axis_tdata[7:0], want.read_data);
                    if (m_axis_tdata[11:8] != want.sample)
                        report_mismatch("sample", m_axis_tdata[11:8], want.sample);
                    if (m_axis_tdata[12] != want.channel_on)
                        report_mismatch("channel_on", m_axis_tdata[12], want.channel_on);
                    if (m_axis_tdata[13] != want.dac_on)
                        report_mismatch("dac_on", m_axis_tdata[13], want.dac_on);
                    if (m_axis_tdata[15:14] != 2'b00)
                        report_mismatch("tdata fill", m_axis_tdata[15:14], 0);
                end
                result_no++;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                apply_beat(s_axis_tuser, s_axis_tdata[1:0], s_axis_tdata[9:2],
                           s_axis_tdata[17:10], fresh);
                expected_beats.push_back(fresh);
            end
            results_pending = expected_beats.size();
        end
    end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench top for noise_channel_lfsr_envelope_core: clock, reset, s_axis stimulus,
// m_axis back-pressure and the verdict. Depends on ncle_pkg and noise_channel_checker.
module tb_top;
    import ncle_pkg::*;

    // Opcodes the core decodes as no-ops
    localparam logic [2:0] FUNC_SPARE_FIRST = 3'd5;
    localparam logic [2:0] FUNC_SPARE_LAST  = 3'd7;
    // Control register bits
    localparam logic [7:0] CTRL_TRIGGER   = 8'h80;
    localparam logic [7:0] CTRL_LENGTH_EN = 8'h40;

    localparam int TOTAL_BEATS   = 660;
    localparam int QUIET_END     = 175;   // no idling in the random part until this many beats are sent
    localparam int IDLE_PERCENT  = 27;
    localparam int TAIL_CYCLES   = 8;

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic [S_TUSER_W-1:0] s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;

    int mismatch_count;
    int results_pending;
    int beats_sent;
    bit idle_gaps;

    noise_channel_lfsr_envelope_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    noise_channel_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    // 8 ns clock
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Result side: drop tready at random while idling is on, else always take the beat
    initial m_axis_tready = 1'b0;
    always @(negedge clk)
    begin
        m_axis_tready <= idle_gaps ? ($urandom_range(0, 99) >= IDLE_PERCENT) : 1'b1;
    end

    // Present one beat at a falling edge and hold it until the core takes it.
    // Valid stays high into the next beat unless an idle gap is drawn.
    task automatic send_beat(input logic [2:0] func, input logic [1:0] idx,
                             input logic [7:0] data, input logic [7:0] cyc);
        if (idle_gaps) begin
            while ($urandom_range(0, 99) < IDLE_PERCENT) begin
                // idle: drop valid and scramble the payload
                s_axis_tvalid <= 1'b0;
                s_axis_tdata  <= {6'd0, 18'($urandom)};
                s_axis_tuser  <= 3'($urandom);
                @(negedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, cyc, data, idx};
        s_axis_tuser  <= func;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        beats_sent++;
        @(negedge clk);
    endtask

    // Hold off the sender until every queued result has come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (results_pending != 0);
    endtask

    initial
    begin
        int         ops;
        int         pick;
        logic [2:0] func;
        logic [7:0] env;
        logic [7:0] poly;
        logic [7:0] ctrl;
        logic [7:0] len;
        logic [7:0] cyc;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        beats_sent    = 0;
        idle_gaps     = 1'b1;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // ---- Directed part ----
        // Read back all four registers in their reset state
        send_beat(FUNC_READ, REG_LENGTH, 8'h00, 8'h00);
        send_beat(FUNC_READ, REG_ENVELOPE, 8'hFF, 8'hFF);
        send_beat(FUNC_READ, REG_POLY, 8'h00, 8'h00);
        send_beat(FUNC_READ, REG_CONTROL, 8'hFF, 8'hFF);
        // Advance by zero cycles on an expired timer: still steps
        send_beat(FUNC_ADVANCE, REG_LENGTH, 8'h00, 8'h00);
        // Trigger with the DAC off: channel stays disabled
        send_beat(FUNC_WRITE, REG_CONTROL, CTRL_TRIGGER, 8'h00);
        // Length one tick from the end, full rising envelope, short mode with divider 0
        send_beat(FUNC_WRITE, REG_LENGTH, 8'h3F, 8'h00);
        send_beat(FUNC_WRITE, REG_ENVELOPE, 8'hFF, 8'h00);
        send_beat(FUNC_WRITE, REG_POLY, 8'h08, 8'h00);
        send_beat(FUNC_WRITE, REG_CONTROL, CTRL_TRIGGER | CTRL_LENGTH_EN, 8'h00);
        send_beat(FUNC_ADVANCE, REG_LENGTH, 8'h00, 8'hFF);
        send_beat(FUNC_ADVANCE, REG_LENGTH, 8'h00, 8'hFF);
        // Envelope already at full volume: counts down only
        send_beat(FUNC_ENVELOPE, REG_LENGTH, 8'h00, 8'h00);
        // Length reaches its limit and disables the channel, then stops counting
        send_beat(FUNC_LENGTH, REG_LENGTH, 8'h00, 8'h00);
        send_beat(FUNC_LENGTH, REG_LENGTH, 8'h00, 8'h00);
        // Falling envelope of period 1 from volume 1, slowest timer, length disabled
        send_beat(FUNC_WRITE, REG_ENVELOPE, 8'h11, 8'h00);
        send_beat(FUNC_WRITE, REG_POLY, 8'hF7, 8'h00);
        send_beat(FUNC_WRITE, REG_CONTROL, CTRL_TRIGGER, 8'h00);
        send_beat(FUNC_ENVELOPE, REG_LENGTH, 8'h00, 8'h00);
        send_beat(FUNC_ADVANCE, REG_LENGTH, 8'h00, 8'h00);
        send_beat(FUNC_LENGTH, REG_LENGTH, 8'h00, 8'h00);
        // Undecoded opcodes leave the state alone
        send_beat(FUNC_SPARE_FIRST, REG_CONTROL, 8'hFF, 8'hFF);
        send_beat(FUNC_SPARE_FIRST + 3'd1, REG_POLY, 8'hAA, 8'h55);
        send_beat(FUNC_SPARE_LAST, REG_ENVELOPE, 8'h55, 8'hAA);
        send_beat(FUNC_READ, REG_CONTROL, 8'h00, 8'h00);
        drain_results();

        // ---- Random part ----
        // Each episode sets up the registers, usually triggers, then runs a burst of
        // ticks, reads and stray writes. Start with a stretch with no idling at all.
        while (beats_sent < TOTAL_BEATS) begin
            idle_gaps = (beats_sent >= QUIET_END);
            if ($urandom_range(0, 5) == 0)
                drain_results();

            len = 8'($urandom);
            if ($urandom_range(0, 9) < 3)
                len[5:0] = 6'($urandom_range(56, 63));
            send_beat(FUNC_WRITE, REG_LENGTH, len, 8'($urandom));

            // mostly DAC on, sometimes off
            if ($urandom_range(0, 99) < 85)
                env = 8'($urandom_range(8, 255));
            else
                env = 8'($urandom_range(0, 7));
            send_beat(FUNC_WRITE, REG_ENVELOPE, env, 8'($urandom));

            // favor short shifts so the register steps often
            poly = 8'($urandom);
            if ($urandom_range(0, 99) < 70)
                poly[7:4] = 4'($urandom_range(0, 2));
            send_beat(FUNC_WRITE, REG_POLY, poly, 8'($urandom));

            ctrl = 8'($urandom);
            if ($urandom_range(0, 9) != 0)
                ctrl = ctrl | CTRL_TRIGGER;
            send_beat(FUNC_WRITE, REG_CONTROL, ctrl, 8'($urandom));

            ops = $urandom_range(8, 40);
            repeat (ops) begin
                pick = $urandom_range(0, 99);
                if ($urandom_range(0, 3) == 0)
                    cyc = 8'($urandom_range(0, 15));
                else
                    cyc = 8'($urandom);
                if (pick < 45)
                    func = FUNC_ADVANCE;
                else if (pick < 60)
                    func = FUNC_LENGTH;
                else if (pick < 75)
                    func = FUNC_ENVELOPE;
                else if (pick < 85)
                    func = FUNC_READ;
                else if (pick < 96)
                    func = FUNC_WRITE;
                else
                    func = 3'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST));
                send_beat(func, 2'($urandom), 8'($urandom), cyc);
            end
        end

        // Wait out the remaining results, then let any stray result beats show
        drain_results();
        repeat (TAIL_CYCLES) @(negedge clk);

        if (mismatch_count == 0 && results_pending == 0)
            $display("PASS noise_channel_lfsr_envelope_core");
        else
            $display("FAIL noise_channel_lfsr_envelope_core");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("FAIL noise_channel_lfsr_envelope_core");
        $finish;
    end

endmodule
